[rtl/q15fd_pkg.sv]
// q15fd_pkg: shared widths and constants for the Q15 fraction divider.
// No dependencies.
`timescale 1ns / 1ps

package q15fd_pkg;

  localparam int DIVIDEND_W = 17;
  localparam int DIVISOR_W  = 32;
  localparam int QUOTIENT_W = 16;
  localparam int S_TDATA_W  = 56;   // 17 + 32 bits, padded to 7 bytes
  localparam int M_TDATA_W  = 16;
  localparam int STEPS      = 32;   // quotient bits, one per cycle
  localparam int CNT_W      = 5;
  localparam int MAG_W      = 17;   // dividend magnitude, up to 65536
  localparam int LEAD_W     = 5;    // leading-one index, 0..16

  localparam logic [QUOTIENT_W-1:0] SAT_Q  = 16'h7fff;
  localparam logic [QUOTIENT_W-1:0] ZERO_Q = 16'h0000;

  typedef logic [DIVIDEND_W-1:0] dividend_t;
  typedef logic [DIVISOR_W-1:0]  divisor_t;
  typedef logic [QUOTIENT_W-1:0] quotient_t;

endpackage

[rtl/q15_fraction_divider.sv]
// q15_fraction_divider: signed dividend over signed divisor, Q15 quotient.
// Restoring divider, one quotient bit per cycle. Depends on q15fd_pkg.
`timescale 1ns / 1ps

//  channel | direction | fields (low bit first)
//  s_*     | in        | tdata: dividend[16:0], divisor[48:17], zero pad [55:49]
//  m_*     | out       | tdata: quotient[15:0]
//
//  Normal item: a setup step in IDLE, the divide loop in ST_DIV, then a finish step in ST_FIN.
//  Zero dividend, zero divisor or saturation skip the divide loop and go straight to ST_FIN.
//  The 32-step quotient loop sets the rate; one item is in work at a time.
//  Result sits in an output register; the next item is taken while it waits.
//  rst is synchronous and clears control state only.

module q15_fraction_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [q15fd_pkg::S_TDATA_W-1:0]   s_tdata,   // dividend, divisor
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [q15fd_pkg::M_TDATA_W-1:0]   m_tdata    // quotient
);
  import q15fd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [CNT_W-1:0]     cnt;
  logic [LEAD_W-1:0]    lead;
  logic                 neg;
  logic                 special;
  quotient_t            preset;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W-1:0] num;
  logic [DIVISOR_W-1:0] quo;

  dividend_t            in_a;
  divisor_t             in_b;
  logic                 a_neg;
  logic                 b_neg;
  logic [MAG_W-1:0]     a_mag;
  logic [DIVISOR_W-1:0] b_mag;
  logic [LEAD_W-1:0]    a_lead;
  logic [DIVISOR_W-1:0] a_norm;
  logic                 in_special;
  quotient_t            in_preset;
  logic                 in_neg;

  logic [DIVISOR_W:0]   rem_sh;
  logic                 q_bit;
  logic [DIVISOR_W-1:0] rem_step;
  logic [DIVISOR_W-1:0] q_sh;
  quotient_t            q_hi;
  quotient_t            base;
  quotient_t            res;
  logic                 s_xfer;
  logic                 out_free;

  assign s_tready = (state == ST_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // operand setup
  always_comb begin
    in_a   = s_tdata[DIVIDEND_W-1:0];
    in_b   = s_tdata[DIVIDEND_W+DIVISOR_W-1:DIVIDEND_W];
    a_neg  = in_a[DIVIDEND_W-1];
    b_neg  = in_b[DIVISOR_W-1];
    a_mag  = a_neg ? (~in_a + 1'b1) : in_a;
    b_mag  = b_neg ? (~in_b + 1'b1) : in_b;
    a_lead = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (a_mag[i]) begin
        a_lead = LEAD_W'(i);
      end
    end
    a_norm = {{(DIVISOR_W-MAG_W){1'b0}}, a_mag} << (5'(DIVISOR_W-1) - a_lead);
    in_neg = (b_mag == '0) ? a_neg : (a_neg ^ b_neg);
    in_special = (b_mag == '0) || ({{(DIVISOR_W-MAG_W){1'b0}}, a_mag} >= b_mag);
    in_preset  = SAT_Q;
    if (a_mag == '0 && b_mag != '0) begin
      in_special = 1'b1;
      in_preset  = ZERO_Q;
    end
  end

  // divide step
  always_comb begin
    rem_sh   = {rem, num[DIVISOR_W-1]};
    q_bit    = (rem_sh >= {1'b0, dvs});
    rem_step = q_bit ? DIVISOR_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIVISOR_W-1:0];
  end

  // shift back, round, apply sign
  always_comb begin
    q_sh = quo << lead;
    q_hi = q_sh[DIVISOR_W-1:DIVISOR_W-QUOTIENT_W]
           + {{(QUOTIENT_W-1){1'b0}}, q_sh[DIVISOR_W-QUOTIENT_W-1]};
    base = special ? preset : q_hi;
    res  = (neg && base != '0) ? (~base + 1'b1) : base;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          state_next = in_special ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      neg     <= in_neg;
      special <= in_special;
      preset  <= in_preset;
      lead    <= a_lead;
      num     <= a_norm;
      dvs     <= b_mag;
      rem     <= '0;
      quo     <= '0;
      cnt     <= CNT_W'(STEPS-1);
    end else if (state == ST_DIV) begin
      rem <= rem_step;
      num <= {num[DIVISOR_W-2:0], 1'b0};
      quo <= {quo[DIVISOR_W-2:0], q_bit};
      cnt <= cnt - 1'b1;
    end
    if (state == ST_FIN && out_free) begin
      m_tdata <= res;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < dvs)
    else $error("remainder not below divisor");

  a_loop_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && cnt == '0 |=> state == ST_FIN)
    else $error("divide loop did not finish");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_xfer |=> !s_tready)
    else $error("took a transfer while busy");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_FIN)
    else $error("result shown without a finished item");

endmodule

[sim/q15_fraction_divider_tb.sv]
// q15_fraction_divider_tb: self-checking bench for the Q15 fraction divider.
// Directed table and random operands, each quotient checked against its table value or a local predictor.
// Depends on q15fd_pkg and q15_fraction_divider.
`timescale 1ns / 1ps

module q15_fraction_divider_tb;
  import q15fd_pkg::*;

  localparam int        RANDOM_ITEMS = 400;
  localparam int        QUIET_TAIL   = 60;
  localparam int        HOLD_CYCLES  = 300;
  localparam int        DRAIN_CYCLES = 40;
  localparam quotient_t NEG_SAT_Q    = 16'h8001;

  typedef struct packed {
    dividend_t dvd;
    divisor_t  dvs;
    logic      known;
    quotient_t q;
  } div_row_t;

  localparam int N_ROWS = 24;
  localparam div_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{17'sd0,       32'sd0,           1'b1, SAT_Q},      // zero over zero
    '{17'sd0,       32'sd7,           1'b1, ZERO_Q},
    '{17'sd0,       -32'sd7,          1'b1, ZERO_Q},
    '{17'sd0,       32'h80000000,     1'b1, ZERO_Q},
    '{17'sd5,       32'sd0,           1'b1, SAT_Q},
    '{-17'sd5,      32'sd0,           1'b1, NEG_SAT_Q},
    '{17'sd100,     32'sd50,          1'b1, SAT_Q},
    '{-17'sd100,    32'sd50,          1'b1, NEG_SAT_Q},
    '{17'sd100,     -32'sd50,         1'b1, NEG_SAT_Q},
    '{-17'sd100,    -32'sd50,         1'b1, SAT_Q},
    '{17'sd50,      32'sd50,          1'b1, SAT_Q},
    '{17'h10000,    32'sd65536,       1'b1, NEG_SAT_Q},  // most negative dividend
    '{17'sd1,       32'sd2,           1'b0, ZERO_Q},
    '{-17'sd1,      32'sd2,           1'b0, ZERO_Q},
    '{17'sd1,       32'sd3,           1'b0, ZERO_Q},
    '{17'sd65535,   32'sd65536,       1'b0, ZERO_Q},     // rounds past 0x7fff
    '{-17'sd65535,  32'sd65536,       1'b0, ZERO_Q},
    '{17'sd65535,   -32'sd65536,      1'b0, ZERO_Q},
    '{17'h10000,    32'h80000000,     1'b0, ZERO_Q},
    '{17'h10000,    32'sd65537,       1'b0, ZERO_Q},
    '{17'sd65535,   32'h7fffffff,     1'b0, ZERO_Q},
    '{-17'sd65535,  32'h80000001,     1'b0, ZERO_Q},
    '{17'sd1,       32'h7fffffff,     1'b0, ZERO_Q},
    '{17'sd3,       32'h80000000,     1'b0, ZERO_Q}
  };

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // dividend[16:0], divisor[48:17], pad
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // quotient[15:0]

  quotient_t pending_quotients [$];
  quotient_t oldest_quotient;
  int        mismatch_count;
  int        items_sent;
  bit        quiet;
  bit        hold_done;

  q15_fraction_divider uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic quotient_t q15_quotient_of(dividend_t dvd, divisor_t dvs);
    logic        neg;
    logic [16:0] mag;
    logic [31:0] dmag;
    logic [63:0] num;
    logic [31:0] q;
    int          msb;
    int          i;
    quotient_t   res;
    mag  = dvd[16] ? -dvd : dvd;
    dmag = dvs[31] ? -dvs : dvs;
    neg  = dvd[16] ^ dvs[31];
    if (dmag == 32'd0) begin
      res = SAT_Q;
      neg = dvd[16];
    end else if ({15'd0, mag} >= dmag) begin
      res = SAT_Q;
    end else if (mag == 17'd0) begin
      res = ZERO_Q;
    end else begin
      msb = 0;
      for (i = 0; i < 17; i++)
        if (mag[i]) msb = i;
      // normalize leading one to bit 31, divide, shift back
      num = 64'(mag) << (31 - msb);
      q   = 32'((num / 64'(dmag)) << msb);
      res = q[31:16] + 16'(q[15]);
    end
    if (neg && res != ZERO_Q) res = -res;
    return res;
  endfunction

  // entered and left at a falling edge
  task automatic send_transfer(input dividend_t dvd, input divisor_t dvs,
                               input logic known, input quotient_t typed_q);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, dvs, dvd};
    do @(posedge clk); while (!s_tready);
    pending_quotients.push_back(known ? typed_q : q15_quotient_of(dvd, dvs));
    items_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_quotients.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected quotient %h", m_tdata);
      end else begin
        oldest_quotient = pending_quotients.pop_front();
        if (m_tdata !== oldest_quotient) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("quotient: expected %h actual %h", oldest_quotient, m_tdata);
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off to back up the block
  initial begin
    m_tready  = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && items_sent >= 100) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    dividend_t   dvd;
    divisor_t    dvs;
    logic [16:0] mag;
    logic [32:0] dmag;
    logic [31:0] raw;
    int          mode;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    mismatch_count = 0;
    items_sent     = 0;
    quiet          = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < N_ROWS; r++)
      send_transfer(DIRECTED_ROWS[r].dvd, DIRECTED_ROWS[r].dvs,
                    DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].q);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      raw = $urandom;
      dvd = raw[16:0];
      if ($urandom_range(0, 3) == 0)
        dvd = dividend_t'($signed(raw[16:0]) >>> $urandom_range(1, 16));
      if ($urandom_range(0, 31) == 0) dvd = 17'h10000;
      mag  = dvd[16] ? -dvd : dvd;
      mode = $urandom_range(0, 19);
      case (mode) inside
        0: begin
          dmag = 33'd0;
        end
        [1:2]: begin
          dmag = {1'b0, 32'($urandom)};
        end
        3: begin
          // at or just below the dividend: saturates
          dmag = {16'd0, mag} - 33'($urandom_range(0, 3));
        end
        4: begin
          dmag = $urandom_range(0, 1) ? 33'h80000000 : 33'h7fffffff;
        end
        default: begin
          dmag = {16'd0, mag} + 33'd1 + ({1'b0, 32'($urandom)} >> $urandom_range(0, 31));
          if (dmag > 33'h80000000) dmag = 33'h80000000;
        end
      endcase
      dvs = $urandom_range(0, 1) ? -dmag[31:0] : dmag[31:0];
      send_transfer(dvd, dvs, 1'b0, ZERO_Q);
    end

    s_tvalid <= 1'b0;
    wait (pending_quotients.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_quotients.size() == 0) begin
      $display("q15_fraction_divider: match");
    end else begin
      $display("q15_fraction_divider: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("q15_fraction_divider: mismatch");
    $finish;
  end

endmodule
